@@ design/irpfd_pkg.sv @@
// shared types, constants and register codes for the infrared pulse frame decoder
`timescale 1ns / 1ps

package irpfd_pkg;

    localparam int INTERVAL_WIDTH_DEF = 16;
    localparam int THRESH_W           = 16;
    localparam int FRAME_BITS         = 32;
    localparam int BIT_POS_W          = $clog2(FRAME_BITS);
    localparam int CFG_INDEX_W        = 8;
    localparam int OUT_TDATA_W        = 40;

    localparam logic [THRESH_W-1:0] FRAME_THRESH_RST = 16'd12500;
    localparam logic [THRESH_W-1:0] BIT_THRESH_RST   = 16'd2000;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_THRESHOLD   = 8'd1;

    localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = BIT_POS_W'(FRAME_BITS - 1);

    // decoded frame, address in the lowest bits
    typedef struct packed {
        logic       check_ok;
        logic [7:0] command_inverse;
        logic [7:0] command;
        logic [7:0] address_inverse;
        logic [7:0] address;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

@@ design/irpfd_decode.sv @@
// frame state and bit decode for one registered pulse interval per cycle while i_fire is high
`timescale 1ns / 1ps

module irpfd_decode #(
    parameter int INTERVAL_WIDTH = irpfd_pkg::INTERVAL_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [INTERVAL_WIDTH-1:0]     i_interval,
    input  logic [irpfd_pkg::THRESH_W-1:0] i_frame_thresh,
    input  logic [irpfd_pkg::THRESH_W-1:0] i_bit_thresh,
    output logic                          o_emit,
    output irpfd_pkg::t_result            o_result
);
    import irpfd_pkg::*;

    localparam int CMP_W = (INTERVAL_WIDTH > THRESH_W) ? INTERVAL_WIDTH : THRESH_W;

    logic                   r_data_phase, n_data_phase;
    logic [BIT_POS_W-1:0]   r_count, n_count;
    logic [FRAME_BITS-1:0]  r_bits, n_bits;
    logic [CMP_W-1:0]       iv_ext, frame_ext, bit_ext;
    logic                   is_one;

    assign iv_ext    = CMP_W'(i_interval);
    assign frame_ext = CMP_W'(i_frame_thresh);
    assign bit_ext   = CMP_W'(i_bit_thresh);
    assign is_one    = iv_ext > bit_ext;

    always_comb begin
        n_data_phase = r_data_phase;
        n_count      = r_count;
        n_bits       = r_bits;
        o_emit       = 1'b0;
        if (i_fire) begin
            if (!r_data_phase) begin
                // first header interval is only counted, the second decides
                if (r_count == '0) begin
                    n_count = BIT_POS_W'(1);
                end else begin
                    n_count = '0;
                    if (iv_ext > frame_ext) begin
                        n_data_phase = 1'b1;
                        n_bits       = '0;
                    end
                end
            end else begin
                n_bits[r_count] = is_one;
                if (r_count == LAST_BIT_POS) begin
                    o_emit       = 1'b1;
                    n_data_phase = 1'b0;
                    n_count      = '0;
                end else begin
                    n_count = r_count + BIT_POS_W'(1);
                end
            end
        end
    end

    assign o_result.address         = n_bits[7:0];
    assign o_result.address_inverse = n_bits[15:8];
    assign o_result.command         = n_bits[23:16];
    assign o_result.command_inverse = n_bits[31:24];
    assign o_result.check_ok        = (n_bits[23:16] == ~n_bits[31:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_phase <= 1'b0;
            r_count      <= '0;
            r_bits       <= '0;
        end else begin
            r_data_phase <= n_data_phase;
            r_count      <= n_count;
            r_bits       <= n_bits;
        end
    end

endmodule

@@ design/irpfd_out_buf.sv @@
// output register with skid entry, keeps the decode side free of downstream ready
`timescale 1ns / 1ps

module irpfd_out_buf #(
    parameter int WIDTH = irpfd_pkg::RESULT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_push_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic             r_main_vld, n_main_vld;
    logic             r_skid_vld, n_skid_vld;
    logic [WIDTH-1:0] r_main, n_main;
    logic [WIDTH-1:0] r_skid, n_skid;

    assign o_push_ready = !r_skid_vld;
    assign o_valid      = r_main_vld;
    assign o_data       = r_main;

    always_comb begin
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (!r_main_vld || i_ready) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_main_vld = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_main     = i_data;
                n_main_vld = i_push;
            end
        end else if (i_push) begin
            // main still waiting for a transfer, park the new result
            n_skid     = i_data;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

@@ design/ir_pulse_frame_decoder.sv @@
// infrared pulse frame decoder: one interval register, decode stage, skid output
// path to m_axis_tvalid: interval register, then decode stage into the output register
// throughput: one interval per cycle while the skid entry is free, combinational bit decode
// a repeat frame or a header interval gives no result
// reset (i_rst_n low, synchronous): header phase, counters and frame bits cleared,
// thresholds back to 12500 and 2000, all valid flags dropped
`timescale 1ns / 1ps

module ir_pulse_frame_decoder #(
    parameter int INTERVAL_WIDTH = irpfd_pkg::INTERVAL_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // interval stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((INTERVAL_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [INTERVAL_WIDTH-1:0] interval
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] address, [15:8] address_inverse, [23:16] command,
    // [31:24] command_inverse, [32] check_ok
    output logic [irpfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [irpfd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [irpfd_pkg::THRESH_W-1:0]    i_cfg_data
);
    import irpfd_pkg::*;

    logic [THRESH_W-1:0]       r_frame_thresh;
    logic [THRESH_W-1:0]       r_bit_thresh;
    logic                      r_in_vld;
    logic [INTERVAL_WIDTH-1:0] r_interval;
    logic                      fire;
    logic                      emit;
    logic                      push_ready;
    t_result                   result;
    logic [RESULT_W-1:0]       out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_thresh <= FRAME_THRESH_RST;
            r_bit_thresh   <= BIT_THRESH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_THRESHOLD: r_frame_thresh <= i_cfg_data;
                CFG_BIT_THRESHOLD:   r_bit_thresh   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the decode stage only moves while the skid entry is free
    assign fire          = r_in_vld && push_ready;
    assign s_axis_tready = !r_in_vld || push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_interval <= s_axis_tdata[INTERVAL_WIDTH-1:0];
        end
    end

    irpfd_decode #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_interval     (r_interval),
        .i_frame_thresh (r_frame_thresh),
        .i_bit_thresh   (r_bit_thresh),
        .o_emit         (emit),
        .o_result       (result)
    );

    irpfd_out_buf #(
        .WIDTH (RESULT_W)
    ) u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (emit),
        .i_data       (result),
        .o_push_ready (push_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (out_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_data);

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the infrared pulse frame decoder
`timescale 1ns / 1ps

module testbench;
    import irpfd_pkg::*;

    localparam int IW          = INTERVAL_WIDTH_DEF;
    localparam int IN_TDATA_W  = ((IW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    // indexes the block must ignore
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = CFG_BIT_THRESHOLD + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = '1;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;   // [15:0] interval
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // [7:0] address, [15:8] address_inverse, [23:16] command,
    // [31:24] command_inverse, [32] check_ok
    logic [OUT_TDATA_W-1:0]      m_axis_tdata;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [THRESH_W-1:0]         i_cfg_data = '0;

    ir_pulse_frame_decoder #(.INTERVAL_WIDTH(IW)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // decoder mirror
    logic [THRESH_W-1:0] frame_thr = FRAME_THRESH_RST;
    logic [THRESH_W-1:0] bit_thr   = BIT_THRESH_RST;
    bit                  in_data_phase = 1'b0;
    logic [4:0]          interval_idx = '0;
    logic [31:0]         frame_acc = '0;

    t_result frames_due [$];
    int      mismatch_count = 0;
    int      frames_checked = 0;
    int      intervals_sent = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      hold_left = 0;

    typedef struct {
        logic [15:0] hdr_first;
        logic [15:0] hdr_second;
        logic [15:0] low_iv;
        logic [15:0] high_iv;
        bit          has_data;
        logic [31:0] pattern;
        bit          typed;
        t_result     want;
    } t_frame_row;

    // thresholds at reset values: 12500 header, 2000 bit
    t_frame_row directed_rows [0:7] = '{
        // second header equal to threshold is a repeat
        '{16'd0,     16'd12500, 16'd0,    16'd0,     1'b0, 32'h0,         1'b0, '0},
        // first header value plays no part
        '{16'hFFFF,  16'd0,     16'd0,    16'd0,     1'b0, 32'h0,         1'b0, '0},
        '{16'd0,     16'd12501, 16'd0,    16'hFFFF,  1'b1, 32'h00FF_00FF, 1'b1,
          33'h1_00FF_00FF},
        // interval one above the bit threshold reads as one
        '{16'd1,     16'hFFFF,  16'd2000, 16'd2001,  1'b1, 32'hFFFF_FFFF, 1'b1,
          33'h0_FFFF_FFFF},
        '{16'hFFFF,  16'hFFFF,  16'd0,    16'hFFFF,  1'b1, 32'h0,         1'b1,
          33'h0_0000_0000},
        '{16'd9000,  16'd13500, 16'd1125, 16'd2250,  1'b1, 32'hE51A_FF00, 1'b1,
          33'h1_E51A_FF00},
        '{16'h5555,  16'hAAAA,  16'h5555, 16'hAAAA,  1'b1, 32'h5AA5_C33C, 1'b0, '0},
        '{16'd12345, 16'd1,     16'd0,    16'd0,     1'b0, 32'h0,         1'b0, '0}
    };

    function automatic bit decode_interval(input logic [15:0] iv, output t_result res);
        res = '0;
        if (!in_data_phase) begin
            if (interval_idx == 0) begin
                interval_idx = 5'd1;
            end else begin
                interval_idx = '0;
                if (iv > frame_thr) begin
                    in_data_phase = 1'b1;
                    frame_acc = '0;
                end
            end
            return 1'b0;
        end
        frame_acc[interval_idx] = (iv > bit_thr);
        if (interval_idx != 5'd31) begin
            interval_idx = interval_idx + 5'd1;
            return 1'b0;
        end
        res.address         = frame_acc[7:0];
        res.address_inverse = frame_acc[15:8];
        res.command         = frame_acc[23:16];
        res.command_inverse = frame_acc[31:24];
        res.check_ok        = (frame_acc[23:16] == ~frame_acc[31:24]);
        in_data_phase = 1'b0;
        interval_idx = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_interval(input logic [15:0] iv, input bit typed, input t_result want);
        t_result res;
        int      gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(iv);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        intervals_sent++;
        if (decode_interval(iv, res)) frames_due.push_back(typed ? want : res);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [THRESH_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_FRAME_THRESHOLD) frame_thr = val;
        else if (idx == CFG_BIT_THRESHOLD) bit_thr = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop offering, wait for every decoded frame, then let a header in flight settle
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [31:0] bits;
        logic [15:0] iv;
        int          r;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            send_interval(16'($urandom), 1'b0, '0);
            if (frame_thr == 16'hFFFF) iv = 16'($urandom);
            else iv = 16'($urandom_range(frame_thr + 1, 16'hFFFF));
            send_interval(iv, 1'b0, '0);
            bits = $urandom;
            if ($urandom_range(0, 1)) bits[31:24] = ~bits[23:16];
            for (int b = 0; b < 32; b++) begin
                r = $urandom_range(0, 9);
                if (bits[b]) begin
                    if (bit_thr == 16'hFFFF || r == 1) iv = 16'hFFFF;
                    else if (r == 0) iv = bit_thr + 16'd1;
                    else iv = 16'($urandom_range(bit_thr + 1, 16'hFFFF));
                end else begin
                    if (r == 0) iv = bit_thr;
                    else if (r == 1) iv = '0;
                    else iv = 16'($urandom_range(0, bit_thr));
                end
                send_interval(iv, 1'b0, '0);
            end
        end else if (pick < 87) begin
            // repeat frame
            send_interval(16'($urandom), 1'b0, '0);
            send_interval(16'($urandom_range(0, frame_thr)), 1'b0, '0);
        end else begin
            // noise, usually leaves the decoder out of step with the frames
            repeat ($urandom_range(1, 40)) send_interval(16'($urandom), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [15:0] ft, input logic [15:0] bt, input int idle,
                             input int stall, input int n, input bit pressure);
        int target;
        int frames;
        settle_block();
        cfg_write(CFG_FRAME_THRESHOLD, ft);
        cfg_write(CFG_BIT_THRESHOLD, bt);
        @(posedge i_clk);
        send_idle_pct = idle;
        stall_pct = stall;
        if (pressure) hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        target = intervals_sent + n;
        frames = 0;
        while (intervals_sent < target) begin
            send_random_frame();
            frames++;
            if (pressure && frames % 5 == 0) begin
                s_axis_tvalid <= 1'b0;
                do @(negedge i_clk); while (frames_due.size() != 0);
            end
        end
    endtask

    // result side
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RESULT_W-1:0];
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected frame", got, 0);
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                if (got.address != want.address)
                    report_mismatch("address", got.address, want.address);
                if (got.address_inverse != want.address_inverse)
                    report_mismatch("address_inverse", got.address_inverse,
                                    want.address_inverse);
                if (got.command != want.command)
                    report_mismatch("command", got.command, want.command);
                if (got.command_inverse != want.command_inverse)
                    report_mismatch("command_inverse", got.command_inverse,
                                    want.command_inverse);
                if (got.check_ok != want.check_ok)
                    report_mismatch("check_ok", got.check_ok, want.check_ok);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, frames_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_interval(directed_rows[r].hdr_first, 1'b0, '0);
            send_interval(directed_rows[r].hdr_second, 1'b0, '0);
            if (directed_rows[r].has_data) begin
                for (int b = 0; b < 32; b++) begin
                    send_interval(directed_rows[r].pattern[b] ? directed_rows[r].high_iv
                                                              : directed_rows[r].low_iv,
                                  directed_rows[r].typed, directed_rows[r].want);
                end
            end
        end

        run_phase(16'd12500, 16'd2000, 0,  0,  220, 1'b1);
        run_phase(16'd0,     16'hFFFF, 71, 0,  210, 1'b0);
        // no data frame can pass this header threshold
        run_phase(16'hFFFF,  16'd0,    0,  71, 100, 1'b0);
        settle_block();
        cfg_write(CFG_UNUSED_LOW, 16'($urandom));
        cfg_write(CFG_UNUSED_HIGH, 16'($urandom));
        run_phase(16'($urandom_range(0, 40000)), 16'($urandom), 19, 19, 210, 1'b0);
        run_phase(16'd0,     16'd0,    19, 19, 210, 1'b0);
        run_phase(16'($urandom_range(0, 40000)), 16'($urandom), 0,  0,  210, 1'b0);

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (frames_due.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d intervals, %0d decoded frames checked", intervals_sent,
                 frames_checked);
        $display("thresholds at reset, both extremes and random; idle, stall and hold-off mixes");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/irpfd_pkg.sv
design/irpfd_decode.sv
design/irpfd_out_buf.sv
design/ir_pulse_frame_decoder.sv
test/testbench.sv
